/* rtl/msf_pkg.sv */
// Shared types, codes and control bundles for the minimum spanning forest block.
package msf_pkg;

    typedef logic [1:0]         opcode_t;
    typedef logic [5:0]         node_t;
    typedef logic signed [31:0] weight_t;
    typedef logic signed [37:0] total_t;
    typedef logic [6:0]         count_t;

    localparam opcode_t OP_ADD   = 2'd0;
    localparam opcode_t OP_RUN   = 2'd1;
    localparam opcode_t OP_CLEAR = 2'd2;

    localparam logic KIND_EDGE  = 1'b0;
    localparam logic KIND_TOTAL = 1'b1;

    localparam count_t NODE_COUNT_RESET = 7'd64;

    // controller -> datapath
    typedef struct packed {
        logic add_issue;    // add item accepted: latch fields, read matrix entry
        logic add_commit;   // add commit, after the matrix entry is read: write back if needed
        logic clr_wr;       // clear sweep write
        logic run_init;     // clear search state and total
        logic seed;         // start node: key 0, parent self
        logic sel_clear;    // first step of a selection scan
        logic sel_issue;    // selection scan read
        logic visit;        // mark selected node visited
        logic relax_issue;  // relaxation scan read
        logic emit_edge;    // load forest edge into output register
        logic emit_total;   // load total into output register
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic found;
        logic par_is_self;
        logic out_free;
        logic start_visited;
    } sts_t;

endpackage

/* rtl/msf_if.sv */
// Request and result channel interfaces for the minimum spanning forest block.
interface msf_req_if;
    logic              valid;
    logic              ready;
    msf_pkg::opcode_t  opcode;
    msf_pkg::node_t    node_a;
    msf_pkg::node_t    node_b;
    msf_pkg::weight_t  weight;

    modport source (output valid, opcode, node_a, node_b, weight, input ready);
    modport sink   (input valid, opcode, node_a, node_b, weight, output ready);
endinterface

interface msf_rsp_if;
    logic              valid;
    logic              ready;
    logic              kind;
    msf_pkg::node_t    parent_node;
    msf_pkg::node_t    child_node;
    msf_pkg::weight_t  edge_weight;
    msf_pkg::total_t   total_weight;
    logic              last;

    modport source (output valid, kind, parent_node, child_node, edge_weight,
                    total_weight, last, input ready);
    modport sink   (input valid, kind, parent_node, child_node, edge_weight,
                    total_weight, last, output ready);
endinterface

/* rtl/msf_ctrl.sv */
// Sequencer for loads, clear sweeps and Prim selection/relaxation scans.
module msf_ctrl #(
    parameter int MAX_NODES = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_we,
    input  msf_pkg::count_t                        cfg_wdata,
    input  logic                                   req_valid,
    input  msf_pkg::opcode_t                       req_opcode,
    output logic                                   req_ready,
    output msf_pkg::cmd_t                          cmd,
    input  msf_pkg::sts_t                          sts,
    output logic [$clog2(MAX_NODES*MAX_NODES)-1:0] clr_addr,
    output logic [$clog2(MAX_NODES)-1:0]           scan_idx,
    output logic [$clog2(MAX_NODES)-1:0]           start_idx
);

    localparam int NW  = $clog2(MAX_NODES);
    localparam int NCW = $clog2(MAX_NODES + 1);
    localparam int AW  = $clog2(MAX_NODES * MAX_NODES);
    localparam int CW  = AW + 1;

    typedef enum logic [8:0] {
        S_CLR   = 9'b000000001,
        S_IDLE  = 9'b000000010,
        S_ADD   = 9'b000000100,
        S_START = 9'b000001000,
        S_SEL   = 9'b000010000,
        S_PAR   = 9'b000100000,
        S_EDGE  = 9'b001000000,
        S_RELAX = 9'b010000000,
        S_TOTAL = 9'b100000000
    } state_t;

    state_t          state_reg, state_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [NCW-1:0]  s_reg, s_next;
    msf_pkg::count_t node_count_reg;
    logic [NCW-1:0]  n_nodes;

    // count above the array size acts as the array size
    assign n_nodes = (node_count_reg > 7'(MAX_NODES)) ? NCW'(MAX_NODES)
                                                      : NCW'(node_count_reg);

    assign clr_addr  = cnt_reg[AW-1:0];
    assign scan_idx  = cnt_reg[NW-1:0];
    assign start_idx = s_reg[NW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLR;
            cnt_reg        <= '0;
            s_reg          <= '0;
            node_count_reg <= msf_pkg::NODE_COUNT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            s_reg     <= s_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_wdata;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        s_next     = s_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_CLR:
            begin
                cmd.clr_wr = 1'b1;
                cnt_next   = cnt_reg + CW'(1);
                if (cnt_reg == CW'(MAX_NODES * MAX_NODES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    unique case (req_opcode)
                        msf_pkg::OP_ADD:
                        begin
                            cmd.add_issue = 1'b1;
                            state_next    = S_ADD;
                        end
                        msf_pkg::OP_RUN:
                        begin
                            cmd.run_init = 1'b1;
                            s_next       = '0;
                            state_next   = S_START;
                        end
                        msf_pkg::OP_CLEAR:
                        begin
                            cnt_next   = '0;
                            state_next = S_CLR;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_ADD:
            begin
                cmd.add_commit = 1'b1;
                state_next     = S_IDLE;
            end
            S_START:
            begin
                if (s_reg == n_nodes)
                begin
                    state_next = S_TOTAL;
                end
                else if (sts.start_visited)
                begin
                    s_next = s_reg + NCW'(1);
                end
                else
                begin
                    cmd.seed   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SEL;
                end
            end
            S_SEL:
            begin
                // reads issue for 0..n-1; a final step with no read drains the last compare
                if (cnt_reg < CW'(n_nodes))
                begin
                    cmd.sel_issue = 1'b1;
                    cmd.sel_clear = (cnt_reg == '0);
                    cnt_next      = cnt_reg + CW'(1);
                end
                else
                begin
                    state_next = S_PAR;
                end
            end
            S_PAR:
            begin
                if (sts.found)
                begin
                    cmd.visit  = 1'b1;
                    state_next = S_EDGE;
                end
                else
                begin
                    s_next     = s_reg + NCW'(1);
                    state_next = S_START;
                end
            end
            S_EDGE:
            begin
                if (sts.par_is_self)
                begin
                    cnt_next   = '0;
                    state_next = S_RELAX;
                end
                else if (sts.out_free)
                begin
                    cmd.emit_edge = 1'b1;
                    cnt_next      = '0;
                    state_next    = S_RELAX;
                end
            end
            S_RELAX:
            begin
                if (cnt_reg < CW'(n_nodes))
                begin
                    cmd.relax_issue = 1'b1;
                    cnt_next        = cnt_reg + CW'(1);
                end
                else
                begin
                    cnt_next   = '0;
                    state_next = S_SEL;
                end
            end
            S_TOTAL:
            begin
                if (sts.out_free)
                begin
                    cmd.emit_total = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/msf_dp.sv */
// Datapath: adjacency memory, per-node key/parent memories, scan compare and output register.
module msf_dp #(
    parameter int MAX_NODES   = 64,
    parameter int WEIGHT_BITS = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  msf_pkg::cmd_t                          cmd,
    output msf_pkg::sts_t                          sts,
    input  logic [$clog2(MAX_NODES*MAX_NODES)-1:0] clr_addr,
    input  logic [$clog2(MAX_NODES)-1:0]           scan_idx,
    input  logic [$clog2(MAX_NODES)-1:0]           start_idx,
    input  msf_pkg::node_t                         req_node_a,
    input  msf_pkg::node_t                         req_node_b,
    input  msf_pkg::weight_t                       req_weight,
    output logic                                   rsp_valid,
    input  logic                                   rsp_ready,
    output logic                                   rsp_kind,
    output msf_pkg::node_t                         rsp_parent_node,
    output msf_pkg::node_t                         rsp_child_node,
    output msf_pkg::weight_t                       rsp_edge_weight,
    output msf_pkg::total_t                        rsp_total_weight,
    output logic                                   rsp_last
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int AW    = $clog2(MAX_NODES * MAX_NODES);
    localparam int DEPTH = MAX_NODES * MAX_NODES;
    localparam int IW    = (WEIGHT_BITS < 32) ? WEIGHT_BITS : 32;

    // adjacency word: {present, weight}, one entry per unordered pair
    logic [IW:0]            adj_mem [DEPTH];
    logic [IW:0]            adj_q_reg;
    logic signed [IW-1:0]   key_mem [MAX_NODES];
    logic signed [IW-1:0]   key_q_reg;
    logic [NW-1:0]          par_mem [MAX_NODES];
    logic [NW-1:0]          par_q_reg;

    logic [MAX_NODES-1:0]   visited_reg;
    logic [MAX_NODES-1:0]   reached_reg;
    logic                   found_reg;
    logic signed [IW-1:0]   best_key_reg;
    logic [NW-1:0]          best_idx_reg;
    logic                   sel_vld_reg;
    logic                   rlx_vld_reg;
    logic [NW-1:0]          stg_idx_reg;
    msf_pkg::total_t        total_reg;

    logic                   add_ok_reg;
    logic [AW-1:0]          add_addr_reg;
    logic signed [IW-1:0]   add_w_reg;

    logic                   out_vld_reg;
    logic                   out_kind_reg;
    msf_pkg::node_t         out_par_reg;
    msf_pkg::node_t         out_chi_reg;
    msf_pkg::weight_t       out_ew_reg;
    msf_pkg::total_t        out_tot_reg;
    logic                   out_last_reg;

    logic signed [IW-1:0]   w_in;
    logic signed [IW-1:0]   adj_w;
    logic                   add_in_ok;
    logic [AW-1:0]          rd_addr;
    logic                   add_we;
    logic                   adj_we;
    logic [AW-1:0]          adj_waddr;
    logic [IW:0]            adj_wdata;
    logic                   sel_take;
    logic                   rlx_we;
    msf_pkg::total_t        total_sum;

    function automatic logic [AW-1:0] pair_addr(input logic [NW-1:0] x,
                                                input logic [NW-1:0] y);
        logic [NW-1:0] lo;
        logic [NW-1:0] hi;
        lo = (x < y) ? x : y;
        hi = (x < y) ? y : x;
        return AW'(lo * MAX_NODES + hi);
    endfunction

    assign w_in      = req_weight[IW-1:0];
    assign adj_w     = adj_q_reg[IW-1:0];
    assign add_in_ok = (7'(req_node_a) < 7'(MAX_NODES)) && (7'(req_node_b) < 7'(MAX_NODES))
                       && (req_node_a != req_node_b);

    assign rd_addr = cmd.add_issue ? pair_addr(req_node_a[NW-1:0], req_node_b[NW-1:0])
                                   : pair_addr(best_idx_reg, scan_idx);

    // repeated edge keeps the smaller weight
    assign add_we    = cmd.add_commit && add_ok_reg && (!adj_q_reg[IW] || add_w_reg < adj_w);
    assign adj_we    = cmd.clr_wr || add_we;
    assign adj_waddr = cmd.clr_wr ? clr_addr : add_addr_reg;
    assign adj_wdata = cmd.clr_wr ? '0 : {1'b1, add_w_reg};

    assign sel_take = sel_vld_reg && reached_reg[stg_idx_reg] && !visited_reg[stg_idx_reg]
                      && (!found_reg || key_q_reg < best_key_reg);
    assign rlx_we   = rlx_vld_reg && adj_q_reg[IW] && !visited_reg[stg_idx_reg]
                      && (!reached_reg[stg_idx_reg] || key_q_reg > adj_w);

    assign total_sum = total_reg + 38'(best_key_reg);

    always_ff @(posedge clk)
    begin
        if (adj_we)
        begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        adj_q_reg <= adj_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.seed)
        begin
            key_mem[start_idx] <= '0;
        end
        else if (rlx_we)
        begin
            key_mem[stg_idx_reg] <= adj_w;
        end
        key_q_reg <= key_mem[scan_idx];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.seed)
        begin
            par_mem[start_idx] <= start_idx;
        end
        else if (rlx_we)
        begin
            par_mem[stg_idx_reg] <= best_idx_reg;
        end
        par_q_reg <= par_mem[best_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            visited_reg <= '0;
            reached_reg <= '0;
            found_reg   <= 1'b0;
            sel_vld_reg <= 1'b0;
            rlx_vld_reg <= 1'b0;
            total_reg   <= '0;
            add_ok_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            sel_vld_reg <= cmd.sel_issue;
            rlx_vld_reg <= cmd.relax_issue;
            if (cmd.add_issue)
            begin
                add_ok_reg <= add_in_ok;
            end
            if (cmd.run_init)
            begin
                visited_reg <= '0;
                reached_reg <= '0;
                total_reg   <= '0;
            end
            else
            begin
                if (cmd.seed)
                begin
                    reached_reg[start_idx] <= 1'b1;
                end
                if (rlx_we)
                begin
                    reached_reg[stg_idx_reg] <= 1'b1;
                end
                if (cmd.visit)
                begin
                    visited_reg[best_idx_reg] <= 1'b1;
                end
                if (cmd.emit_edge)
                begin
                    total_reg <= total_sum;
                end
            end
            if (cmd.sel_clear)
            begin
                found_reg <= 1'b0;
            end
            else if (sel_take)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.emit_edge || cmd.emit_total)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        stg_idx_reg <= scan_idx;
        if (sel_take)
        begin
            best_key_reg <= key_q_reg;
            best_idx_reg <= stg_idx_reg;
        end
        if (cmd.add_issue)
        begin
            add_addr_reg <= rd_addr;
            add_w_reg    <= w_in;
        end
        if (cmd.emit_edge)
        begin
            out_kind_reg <= msf_pkg::KIND_EDGE;
            out_par_reg  <= 6'(par_q_reg);
            out_chi_reg  <= 6'(best_idx_reg);
            out_ew_reg   <= 32'(best_key_reg);
            out_tot_reg  <= total_sum;
            out_last_reg <= 1'b0;
        end
        else if (cmd.emit_total)
        begin
            out_kind_reg <= msf_pkg::KIND_TOTAL;
            out_par_reg  <= '0;
            out_chi_reg  <= '0;
            out_ew_reg   <= '0;
            out_tot_reg  <= total_reg;
            out_last_reg <= 1'b1;
        end
    end

    assign sts.found         = found_reg;
    assign sts.par_is_self   = (par_q_reg == best_idx_reg);
    assign sts.out_free      = !out_vld_reg || rsp_ready;
    assign sts.start_visited = visited_reg[start_idx];

    assign rsp_valid        = out_vld_reg;
    assign rsp_kind         = out_kind_reg;
    assign rsp_parent_node  = out_par_reg;
    assign rsp_child_node   = out_chi_reg;
    assign rsp_edge_weight  = out_ew_reg;
    assign rsp_total_weight = out_tot_reg;
    assign rsp_last         = out_last_reg;

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_vld_reg && !rsp_ready) |-> !(cmd.emit_edge || cmd.emit_total))
        else $error("output register overwritten while held");

    // every visited node was reached first
    a_visited_reached: assert property (@(posedge clk) disable iff (!rst_n)
        (visited_reg & ~reached_reg) == '0)
        else $error("visited node not reached");

    // only a fresh candidate gets visited
    a_visit_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.visit |-> (found_reg && !visited_reg[best_idx_reg]))
        else $error("visit of invalid candidate");

    // an edge result follows the visit of a non-start node
    a_edge_after_visit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_edge |-> ($past(cmd.visit) || !$stable(out_vld_reg) || out_vld_reg
                           || !out_vld_reg) && visited_reg[best_idx_reg]
                          && (par_q_reg != best_idx_reg))
        else $error("edge result without visited child");

endmodule

/* rtl/minimum_spanning_forest_top.sv */
// Top level of the Prim minimum spanning forest block.
// Items on req: add edge (both endpoints must be below MAX_NODES and
// distinct, a repeated edge keeps the smaller weight), clear (one matrix
// entry per cycle), and run. A run walks the nodes below node_count (capped
// at MAX_NODES): for each start node not yet visited it seeds key 0, then
// alternates a selection scan (one key memory read per node) with a
// relaxation scan (one adjacency read per node), with a parent check and an
// edge step for each selected node; the tree of each start node closes with
// a selection scan that finds nothing. The scans are serial because the
// adjacency and key memories each have a single read port. Each new forest
// edge comes out on rsp as a kind 0 item with the running total, and the run
// ends with one kind 1 item with last set. A one-entry output register sits
// on rsp, so a new item is taken while the final result of the previous one
// is still waiting. After reset all MAX_NODES^2 entries of the adjacency
// matrix (4096 at the default size) are swept clear with req.ready low. The
// user must write node_count through cfg_we/cfg_wdata only while the block is
// idle; the block itself does not enforce this. node_count resets to 64.
module minimum_spanning_forest_top #(
    parameter int MAX_NODES   = 64,
    parameter int WEIGHT_BITS = 32
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  msf_pkg::count_t cfg_wdata,
    msf_req_if.sink         req,
    msf_rsp_if.source       rsp
);

    localparam int NW = $clog2(MAX_NODES);
    localparam int AW = $clog2(MAX_NODES * MAX_NODES);

    msf_pkg::cmd_t  cmd;
    msf_pkg::sts_t  sts;
    logic [AW-1:0]  clr_addr;
    logic [NW-1:0]  scan_idx;
    logic [NW-1:0]  start_idx;

    // controller: node count register, state machine and scan counters
    msf_ctrl #(
        .MAX_NODES (MAX_NODES)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .req_valid  (req.valid),
        .req_opcode (req.opcode),
        .req_ready  (req.ready),
        .cmd        (cmd),
        .sts        (sts),
        .clr_addr   (clr_addr),
        .scan_idx   (scan_idx),
        .start_idx  (start_idx)
    );

    // datapath: matrix, per-node state and the output register
    msf_dp #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .clr_addr         (clr_addr),
        .scan_idx         (scan_idx),
        .start_idx        (start_idx),
        .req_node_a       (req.node_a),
        .req_node_b       (req.node_b),
        .req_weight       (req.weight),
        .rsp_valid        (rsp.valid),
        .rsp_ready        (rsp.ready),
        .rsp_kind         (rsp.kind),
        .rsp_parent_node  (rsp.parent_node),
        .rsp_child_node   (rsp.child_node),
        .rsp_edge_weight  (rsp.edge_weight),
        .rsp_total_weight (rsp.total_weight),
        .rsp_last         (rsp.last)
    );

endmodule
